### rtl/atpe_pkg.sv
// Shared constants, codes and controller/datapath interface types for the trace point encoder.
package atpe_pkg;

    localparam int MAX_READ_LEN = 16384;
    localparam int ADDR_W       = $clog2(MAX_READ_LEN);
    localparam int POS_W        = 15;
    localparam int IDX_W        = 14;
    localparam int BASE_W       = 8;
    localparam int DIFF_W       = 9;
    localparam int SPC_W        = 8;
    localparam int ENTRY_W      = 16;
    localparam int CNT_W        = $clog2(POS_W);
    localparam int MAX_SEGMENTS = 62;

    localparam logic [SPC_W-1:0]  SPACING_RESET = 8'd100;
    localparam logic [DIFF_W-1:0] DIFF_MAX      = 9'd511;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_TRACE  = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    typedef enum logic [1:0] {
        DIV_AB,
        DIV_AE,
        DIV_APOS
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     load_a;
        logic     load_b;
        logic     div_load;
        t_div_sel div_sel;
        logic     div_step;
        logic     save_q1;
        logic     start_apply;
        logic     resync;
        logic     col_step;
        logic     post_step;
        logic     fin_second;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic stale;
        logic div_last;
        logic walk_more;
        logic is_finish;
        logic held_more;
    } t_stat;

endpackage

### rtl/alignment_trace_point_encoder_unit.sv
// Top level of the alignment trace point encoder.
//
// Command channel: an item is taken when i_start is high and o_busy is low.
// Op load A/B writes one base into the A or B store; o_busy stays low.
// Op start runs two 15-step remainder divisions for the span check; a
// refused span gives one beat with o_span_error and o_last set in the
// same cycle as o_busy drops. Trace and finish walk the diagonal, each
// aligned column taking a store read and then a compare; a finish that
// closes with two beats goes through one extra state, and a remainder
// division runs before the walk when trace_spacing was rewritten since
// the last start or resync. Each result is one beat on o_valid for one
// cycle, at most one per cycle; the receiver cannot stall. Trace and
// finish items before a start, and unused ops, are dropped.
// Configuration: i_cfg_we writes trace_spacing; write only while idle.
// Reset clears the controller, positions and the held pair; base stores
// are undefined until loaded. trace_spacing returns to 100.
module alignment_trace_point_encoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [2:0]                          i_op,
    input  logic [atpe_pkg::IDX_W-1:0]          i_seq_index,
    input  logic [atpe_pkg::BASE_W-1:0]         i_base_code,
    input  logic [atpe_pkg::IDX_W-1:0]          i_a_begin,
    input  logic [atpe_pkg::IDX_W-1:0]          i_b_begin,
    input  logic [atpe_pkg::POS_W-1:0]          i_a_end,
    input  logic signed [atpe_pkg::ENTRY_W-1:0] i_trace_entry,
    input  logic                                i_cfg_we,
    input  logic [atpe_pkg::SPC_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [atpe_pkg::DIFF_W-1:0]         o_segment_diffs,
    output logic [atpe_pkg::POS_W-1:0]          o_b_advance,
    output logic                                o_last,
    output logic                                o_span_error
);
    import atpe_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    atpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    atpe_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_seq_index     (i_seq_index),
        .i_base_code     (i_base_code),
        .i_a_begin       (i_a_begin),
        .i_b_begin       (i_b_begin),
        .i_a_end         (i_a_end),
        .i_trace_entry   (i_trace_entry),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_segment_diffs (o_segment_diffs),
        .o_b_advance     (o_b_advance),
        .o_last          (o_last),
        .o_span_error    (o_span_error)
    );
endmodule

### rtl/atpe_ram.sv
// Generic single-port RAM with registered read.
module atpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/atpe_ctrl.sv
// Controller state machine sequencing loads, span check, diagonal walk and final pairs.
module atpe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_op,
    input  atpe_pkg::t_stat i_stat,
    output atpe_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import atpe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_E_LD,
        ST_DIV_E,
        ST_START,
        ST_DIV_P,
        ST_RESYNC,
        ST_WALK,
        ST_COL,
        ST_POST,
        ST_FIN2
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD_A: cmd.load_a = 1'b1;
                        OP_LOAD_B: cmd.load_b = 1'b1;
                        OP_START: begin
                            cmd.capture  = 1'b1;
                            cmd.div_load = 1'b1;
                            cmd.div_sel  = DIV_AB;
                            n_state      = ST_DIV_A;
                        end
                        OP_TRACE, OP_FINISH: begin
                            if (i_stat.active) begin
                                cmd.capture = 1'b1;
                                if (i_stat.stale) begin
                                    cmd.div_load = 1'b1;
                                    cmd.div_sel  = DIV_APOS;
                                    n_state      = ST_DIV_P;
                                end else begin
                                    n_state = ST_WALK;
                                end
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV_A: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_DIV_E_LD;
            end
            ST_DIV_E_LD: begin
                cmd.save_q1  = 1'b1;
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_AE;
                n_state      = ST_DIV_E;
            end
            ST_DIV_E: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_START;
            end
            ST_START: begin
                cmd.start_apply = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_DIV_P: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_RESYNC;
            end
            ST_RESYNC: begin
                cmd.resync = 1'b1;
                n_state    = ST_WALK;
            end
            ST_WALK: begin
                n_state = i_stat.walk_more ? ST_COL : ST_POST;
            end
            ST_COL: begin
                cmd.col_step = 1'b1;
                n_state      = ST_WALK;
            end
            ST_POST: begin
                cmd.post_step = 1'b1;
                n_state = (i_stat.is_finish && i_stat.held_more) ? ST_FIN2 : ST_IDLE;
            end
            ST_FIN2: begin
                cmd.fin_second = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);
endmodule

### rtl/atpe_datapath.sv
// Datapath: base stores, position registers, remainder divider, segment closing and result beats.
module atpe_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atpe_pkg::t_cmd                      i_cmd,
    output atpe_pkg::t_stat                     o_stat,
    input  logic [2:0]                          i_op,
    input  logic [atpe_pkg::IDX_W-1:0]          i_seq_index,
    input  logic [atpe_pkg::BASE_W-1:0]         i_base_code,
    input  logic [atpe_pkg::IDX_W-1:0]          i_a_begin,
    input  logic [atpe_pkg::IDX_W-1:0]          i_b_begin,
    input  logic [atpe_pkg::POS_W-1:0]          i_a_end,
    input  logic signed [atpe_pkg::ENTRY_W-1:0] i_trace_entry,
    input  logic                                i_cfg_we,
    input  logic [atpe_pkg::SPC_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [atpe_pkg::DIFF_W-1:0]         o_segment_diffs,
    output logic [atpe_pkg::POS_W-1:0]          o_b_advance,
    output logic                                o_last,
    output logic                                o_span_error
);
    import atpe_pkg::*;

    logic [SPC_W-1:0]   r_spacing, n_spacing;
    logic               r_stale, n_stale;
    logic               r_active, n_active;
    logic [2:0]         r_op, n_op;
    logic [ENTRY_W-1:0] r_entry, n_entry;
    logic [IDX_W-1:0]   r_ab, n_ab, r_bb, n_bb;
    logic [POS_W-1:0]   r_ae, n_ae;
    logic [POS_W-1:0]   r_a_pos, n_a_pos, r_b_pos, n_b_pos, r_a_stop, n_a_stop;
    logic [POS_W-1:0]   r_a_last, n_a_last, r_b_last, n_b_last;
    logic [DIFF_W-1:0]  r_diff, n_diff, r_held_d, n_held_d;
    logic [POS_W-1:0]   r_held_b, n_held_b;
    logic               r_held_v, n_held_v;
    logic [SPC_W-1:0]   r_rem, n_rem, r_r1, n_r1;
    logic [POS_W-1:0]   r_q1, n_q1, r_dq, n_dq;
    logic [SPC_W-1:0]   r_dr, n_dr;
    logic [CNT_W-1:0]   r_dcnt, n_dcnt;
    logic               r_a_oob, r_b_oob;
    logic               r_o_valid, n_o_valid, r_o_last, n_o_last, r_o_err, n_o_err;
    logic [DIFF_W-1:0]  r_o_d, n_o_d;
    logic [POS_W-1:0]   r_o_b, n_o_b;

    logic [SPC_W-1:0]   s_eff;
    logic [BASE_W-1:0]  a_rdata, b_rdata, a_sym, b_sym;
    logic [ADDR_W-1:0]  a_addr, b_addr;
    logic [SPC_W:0]     div_w;
    logic               div_ge;
    logic [SPC_W-1:0]   rem_inc;
    logic [POS_W-1:0]   adv, spread;
    logic               is_fin, is_ins, lt_stop, walk_more;
    logic               step, close;
    logic [DIFF_W-1:0]  step_diff;
    logic [POS_W-1:0]   step_a, step_b;
    logic               span_bad;

    assign s_eff   = (r_spacing == '0) ? SPC_W'(1) : r_spacing;
    assign a_addr  = i_cmd.load_a ? ADDR_W'(i_seq_index) : r_a_pos[ADDR_W-1:0];
    assign b_addr  = i_cmd.load_b ? ADDR_W'(i_seq_index) : r_b_pos[ADDR_W-1:0];

    atpe_ram #(.WIDTH(BASE_W), .DEPTH(MAX_READ_LEN)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_a),
        .i_addr  (a_addr),
        .i_wdata (i_base_code),
        .o_rdata (a_rdata)
    );

    atpe_ram #(.WIDTH(BASE_W), .DEPTH(MAX_READ_LEN)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_b),
        .i_addr  (b_addr),
        .i_wdata (i_base_code),
        .o_rdata (b_rdata)
    );

    assign a_sym   = r_a_oob ? '0 : a_rdata;
    assign b_sym   = r_b_oob ? '0 : b_rdata;
    assign div_w   = {r_dr, r_dq[POS_W-1]};
    assign div_ge  = div_w >= {1'b0, s_eff};
    assign rem_inc = (({1'b0, r_rem} + 1'b1) == {1'b0, s_eff}) ? '0 : r_rem + 1'b1;
    assign adv     = r_b_pos - r_b_last;
    assign spread  = r_dq - r_q1;
    assign span_bad = (r_ae > {1'b0, r_ab}) && (spread > POS_W'(MAX_SEGMENTS - 1));
    assign is_fin  = (r_op == OP_FINISH);
    assign is_ins  = r_entry[ENTRY_W-1];
    assign lt_stop = r_a_pos < r_a_stop;

    always_comb begin
        walk_more = 1'b0;
        if (lt_stop) begin
            if (is_fin) begin
                walk_more = 1'b1;
            end else if (is_ins) begin
                walk_more = {1'b0, r_a_pos} < ~r_entry;
            end else begin
                walk_more = ({2'b0, r_b_pos} + 17'd1) < {1'b0, r_entry};
            end
        end
    end

    always_comb begin
        n_spacing = r_spacing;
        n_stale   = r_stale;
        n_active  = r_active;
        n_op      = r_op;
        n_entry   = r_entry;
        n_ab      = r_ab;
        n_bb      = r_bb;
        n_ae      = r_ae;
        n_a_pos   = r_a_pos;
        n_b_pos   = r_b_pos;
        n_a_stop  = r_a_stop;
        n_a_last  = r_a_last;
        n_b_last  = r_b_last;
        n_diff    = r_diff;
        n_held_d  = r_held_d;
        n_held_b  = r_held_b;
        n_held_v  = r_held_v;
        n_rem     = r_rem;
        n_r1      = r_r1;
        n_q1      = r_q1;
        n_dq      = r_dq;
        n_dr      = r_dr;
        n_dcnt    = r_dcnt;
        n_o_valid = 1'b0;
        n_o_last  = 1'b0;
        n_o_err   = 1'b0;
        n_o_d     = r_o_d;
        n_o_b     = r_o_b;
        step      = 1'b0;
        close     = 1'b0;
        step_diff = r_diff;
        step_a    = r_a_pos;
        step_b    = r_b_pos;

        if (i_cfg_we) begin
            n_spacing = i_cfg_data;
            n_stale   = 1'b1;
        end

        if (i_cmd.capture) begin
            n_op    = i_op;
            n_entry = i_trace_entry;
            n_ab    = i_a_begin;
            n_bb    = i_b_begin;
            n_ae    = i_a_end;
        end

        if (i_cmd.div_load) begin
            n_dr   = '0;
            n_dcnt = '0;
            case (i_cmd.div_sel)
                DIV_AB:   n_dq = {1'b0, i_a_begin};
                DIV_AE:   n_dq = r_ae - 1'b1;
                DIV_APOS: n_dq = r_a_pos;
                default:  n_dq = r_a_pos;
            endcase
        end

        if (i_cmd.div_step) begin
            n_dr   = div_ge ? SPC_W'(div_w - {1'b0, s_eff}) : div_w[SPC_W-1:0];
            n_dq   = {r_dq[POS_W-2:0], div_ge};
            n_dcnt = r_dcnt + 1'b1;
        end

        if (i_cmd.save_q1) begin
            n_q1 = r_dq;
            n_r1 = r_dr;
        end

        if (i_cmd.resync) begin
            n_rem   = r_dr;
            n_stale = 1'b0;
        end

        if (i_cmd.start_apply) begin
            n_held_v = 1'b0;
            n_held_d = '0;
            n_held_b = '0;
            n_diff   = '0;
            if (span_bad) begin
                n_active  = 1'b0;
                n_o_valid = 1'b1;
                n_o_d     = '0;
                n_o_b     = '0;
                n_o_last  = 1'b1;
                n_o_err   = 1'b1;
            end else begin
                n_active = 1'b1;
                n_a_pos  = {1'b0, r_ab};
                n_a_last = {1'b0, r_ab};
                n_b_pos  = {1'b0, r_bb};
                n_b_last = {1'b0, r_bb};
                n_a_stop = r_ae;
                n_rem    = r_r1;
                n_stale  = 1'b0;
            end
        end

        if (i_cmd.col_step) begin
            step      = 1'b1;
            step_diff = ((a_sym != b_sym) && (r_diff != DIFF_MAX)) ? r_diff + 1'b1 : r_diff;
            step_a    = r_a_pos + 1'b1;
            step_b    = r_b_pos + 1'b1;
            close     = (rem_inc == '0) && (!is_fin || (step_a != r_a_stop));
        end

        if (i_cmd.post_step) begin
            if (is_fin) begin
                if (r_a_pos != r_a_last) begin
                    if (r_held_v) begin
                        n_o_valid = 1'b1;
                        n_o_d     = r_held_d;
                        n_o_b     = r_held_b;
                    end else begin
                        n_o_valid = 1'b1;
                        n_o_d     = r_diff;
                        n_o_b     = adv;
                        n_o_last  = 1'b1;
                        n_active  = 1'b0;
                    end
                end else begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    n_active  = 1'b0;
                    n_held_v  = 1'b0;
                    if (r_held_v) begin
                        n_o_d = r_held_d;
                        n_o_b = r_held_b + adv;
                    end else begin
                        n_o_d = r_diff;
                        n_o_b = adv;
                    end
                end
            end else if (is_ins) begin
                n_diff  = (r_diff != DIFF_MAX) ? r_diff + 1'b1 : r_diff;
                n_b_pos = r_b_pos + 1'b1;
            end else if (lt_stop) begin
                step      = 1'b1;
                step_diff = (r_diff != DIFF_MAX) ? r_diff + 1'b1 : r_diff;
                step_a    = r_a_pos + 1'b1;
                step_b    = r_b_pos;
                close     = (rem_inc == '0);
            end
        end

        if (i_cmd.fin_second) begin
            n_o_valid = 1'b1;
            n_o_d     = r_diff;
            n_o_b     = adv;
            n_o_last  = 1'b1;
            n_active  = 1'b0;
            n_held_v  = 1'b0;
        end

        if (step) begin
            n_diff  = step_diff;
            n_a_pos = step_a;
            n_b_pos = step_b;
            n_rem   = rem_inc;
            if (close) begin
                if (r_held_v) begin
                    n_o_valid = 1'b1;
                    n_o_d     = r_held_d;
                    n_o_b     = r_held_b;
                end
                n_held_d = step_diff;
                n_held_b = step_b - r_b_last;
                n_held_v = 1'b1;
                n_a_last = step_a;
                n_b_last = step_b;
                n_diff   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
            r_stale   <= 1'b0;
            r_active  <= 1'b0;
            r_a_pos   <= '0;
            r_b_pos   <= '0;
            r_a_stop  <= '0;
            r_a_last  <= '0;
            r_b_last  <= '0;
            r_diff    <= '0;
            r_held_d  <= '0;
            r_held_b  <= '0;
            r_held_v  <= 1'b0;
            r_rem     <= '0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
            r_o_err   <= 1'b0;
        end else begin
            r_spacing <= n_spacing;
            r_stale   <= n_stale;
            r_active  <= n_active;
            r_a_pos   <= n_a_pos;
            r_b_pos   <= n_b_pos;
            r_a_stop  <= n_a_stop;
            r_a_last  <= n_a_last;
            r_b_last  <= n_b_last;
            r_diff    <= n_diff;
            r_held_d  <= n_held_d;
            r_held_b  <= n_held_b;
            r_held_v  <= n_held_v;
            r_rem     <= n_rem;
            r_o_valid <= n_o_valid;
            r_o_last  <= n_o_last;
            r_o_err   <= n_o_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_entry <= n_entry;
        r_ab    <= n_ab;
        r_bb    <= n_bb;
        r_ae    <= n_ae;
        r_r1    <= n_r1;
        r_q1    <= n_q1;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_dcnt  <= n_dcnt;
        r_o_d   <= n_o_d;
        r_o_b   <= n_o_b;
        r_a_oob <= (r_a_pos[POS_W-1:ADDR_W] != '0);
        r_b_oob <= (r_b_pos[POS_W-1:ADDR_W] != '0);
    end

    assign o_stat.active    = r_active;
    assign o_stat.stale     = r_stale;
    assign o_stat.div_last  = (r_dcnt == CNT_W'(POS_W - 1));
    assign o_stat.walk_more = walk_more;
    assign o_stat.is_finish = is_fin;
    assign o_stat.held_more = r_held_v && (r_a_pos != r_a_last);

    assign o_valid         = r_o_valid;
    assign o_segment_diffs = r_o_d;
    assign o_b_advance     = r_o_b;
    assign o_last          = r_o_last;
    assign o_span_error    = r_o_err;
endmodule

### rtl/atpe_checker.sv
// Port-level checker for the trace point encoder, bound to the top level.
module atpe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic [2:0]                   i_op,
    input logic                         o_valid,
    input logic [atpe_pkg::DIFF_W-1:0]  o_segment_diffs,
    input logic [atpe_pkg::POS_W-1:0]   o_b_advance,
    input logic                         o_last,
    input logic                         o_span_error
);
    import atpe_pkg::*;

    a_flags_need_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last || o_span_error) |-> o_valid)
        else $error("last or span_error without a beat");

    a_span_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span_error |-> (o_last && (o_segment_diffs == '0) && (o_b_advance == '0)))
        else $error("span error beat carries a pair");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && ((i_op == OP_LOAD_A) || (i_op == OP_LOAD_B)))
            |=> (!o_busy && !o_valid))
        else $error("load beat did not complete in one cycle");

    a_start_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_START)) |=> (o_busy && !o_valid))
        else $error("start beat gave an early result");
endmodule

bind alignment_trace_point_encoder_unit atpe_checker u_atpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_op            (i_op),
    .o_valid         (o_valid),
    .o_segment_diffs (o_segment_diffs),
    .o_b_advance     (o_b_advance),
    .o_last          (o_last),
    .o_span_error    (o_span_error)
);
